/* hw/rtl/gcd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd_pkg - shared constants and elaboration-time functions
// Angle reduction constants, radian conversion constants, the CORDIC
// arctangent table and the helpers used to derive the CORDIC gain.
// ---------------------------------------------------------------------------
package gcd_pkg;

	// angles are carried in half-microdegrees
	localparam logic signed [30:0] TURN_HU     = 31'sd720000000;
	localparam logic signed [30:0] HALFTURN_HU = 31'sd360000000;
	localparam logic signed [30:0] QUARTER_HU  = 31'sd180000000;

	// radians Q30 = round(m * PI_Q32 / DIV_C), with PI_Q32 = 9 * DIV_C + PI_EXCESS
	localparam logic [30:0] DIV_C      = 31'd1440000000;
	localparam logic [31:0] DIV_C2     = 32'd2880000000;
	localparam logic [29:0] HALF_C     = 30'd720000000;
	localparam logic [29:0] PI_EXCESS  = 30'd533037705;
	// floor(2^60 / DIV_C), used on the numerator with its low 26 bits dropped
	localparam logic [29:0] RECIP_C    = 30'd800639933;
	localparam int          RECIP_DROP = 26;
	localparam int          RECIP_SH   = 34;

	// stages of the sine/cosine unit ahead of its CORDIC iterations
	localparam int SC_PRE_STAGES = 6;

	localparam longint unsigned ONE60   = 64'h1000_0000_0000_0000;
	localparam logic [22:0]     RADIUS_RESET = 23'd6371000;

	// atan(2^-i) in Q30, rounded
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] v;
		case (i)
			0: v = 30'd843314857;
			1: v = 30'd497837829;
			2: v = 30'd263043837;
			3: v = 30'd133525159;
			4: v = 30'd67021687;
			5: v = 30'd33543516;
			6: v = 30'd16775851;
			7: v = 30'd8388437;
			8: v = 30'd4194283;
			9: v = 30'd2097149;
			default: begin
				// cubic term is below half an LSB from here on
				if (i <= 29) v = 30'(1) << (30 - i);
				else if (i <= 31) v = 30'd1;
				else v = 30'd0;
			end
		endcase
		return v;
	endfunction

	// square of the CORDIC gain in Q60, product of (1 + 2^-2i)
	function automatic longint unsigned gain_sq_q60(input int steps);
		longint unsigned g;
		int i;
		g = ONE60;
		for (i = 0; i < steps; i++) begin
			if (2 * i < 64) g = g + (g >> (2 * i));
		end
		return g;
	endfunction

	// floor square root, bit by bit
	function automatic longint unsigned isqrt_u64(input longint unsigned val);
		longint unsigned v, res, b;
		int i;
		v   = val;
		res = 0;
		b   = 64'h4000_0000_0000_0000;
		for (i = 0; i < 32; i++) begin
			if (v >= res + b) begin
				v   = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

endpackage

/* hw/rtl/gcd_sincos.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gcd_sincos - pipelined sine and cosine of an angle
// Takes an angle in half-microdegrees, folds it to a quarter turn, converts
// to radians Q30 and runs a rotation-mode CORDIC, one iteration per stage.
// The pipeline advances only while en is high.
// ---------------------------------------------------------------------------
module gcd_sincos #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [29:0] angle,
	output logic signed [31:0] sin_q,
	output logic signed [31:0] cos_q
);

	localparam longint unsigned GAIN     = gcd_pkg::isqrt_u64(gcd_pkg::gain_sq_q60(CORDIC_STEPS));
	localparam longint unsigned INV_GAIN = (gcd_pkg::ONE60 + GAIN / 2) / GAIN;
	localparam logic signed [33:0] X_INIT = 34'(INV_GAIN);

	logic signed [30:0] r_s1;
	logic [27:0]        m_s2, m_s3, m_s4, m_s5;
	logic               neg_s2, neg_s3, neg_s4, neg_s5;
	logic               fl_s2, fl_s3, fl_s4, fl_s5, fl_s6;
	logic [57:0]        n2_s3, n2_s4;
	logic [26:0]        qe_s4, qe_s5;
	logic [32:0]        rem_s5;
	logic signed [33:0] z_s6;

	logic signed [30:0] ang_w, r_c, f_c;
	logic               fl_c;
	logic [60:0]        qp_c;
	logic [57:0]        qc_c;
	logic [27:0]        q2_c;
	logic [30:0]        q_c;

	// wrap into half a turn either side of zero
	always_comb begin
		ang_w = {angle[29], angle};
		if (ang_w >= gcd_pkg::HALFTURN_HU) r_c = ang_w - gcd_pkg::TURN_HU;
		else if (ang_w < -gcd_pkg::HALFTURN_HU) r_c = ang_w + gcd_pkg::TURN_HU;
		else r_c = ang_w;
	end

	always_ff @(posedge clk) begin
		if (en) r_s1 <= r_c;
	end

	// fold to a quarter turn, remember the cosine flip
	always_comb begin
		fl_c = 1'b1;
		if (r_s1 > gcd_pkg::QUARTER_HU) f_c = gcd_pkg::HALFTURN_HU - r_s1;
		else if (r_s1 < -gcd_pkg::QUARTER_HU) f_c = -gcd_pkg::HALFTURN_HU - r_s1;
		else begin
			f_c  = r_s1;
			fl_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s2 <= f_c[30];
			m_s2   <= f_c[30] ? 28'(-f_c) : 28'(f_c);
			fl_s2  <= fl_c;
		end
	end

	// fractional part of the radian product
	always_ff @(posedge clk) begin
		if (en) begin
			n2_s3  <= 58'(m_s2) * 58'(gcd_pkg::PI_EXCESS) + 58'(gcd_pkg::HALF_C);
			m_s3   <= m_s2;
			neg_s3 <= neg_s2;
			fl_s3  <= fl_s2;
		end
	end

	// quotient estimate by reciprocal, low by at most two
	assign qp_c = 61'(n2_s3[56:gcd_pkg::RECIP_DROP]) * 61'(gcd_pkg::RECIP_C);

	always_ff @(posedge clk) begin
		if (en) begin
			qe_s4  <= qp_c[gcd_pkg::RECIP_SH +: 27];
			n2_s4  <= n2_s3;
			m_s4   <= m_s3;
			neg_s4 <= neg_s3;
			fl_s4  <= fl_s3;
		end
	end

	// remainder of the estimate
	assign qc_c = 58'(qe_s4) * 58'(gcd_pkg::DIV_C);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5 <= 33'(n2_s4 - qc_c);
			qe_s5  <= qe_s4;
			m_s5   <= m_s4;
			neg_s5 <= neg_s4;
			fl_s5  <= fl_s4;
		end
	end

	// correct the quotient and add the integer part 9m
	always_comb begin
		q2_c = 28'(qe_s5) + 28'(rem_s5 >= 33'(gcd_pkg::DIV_C)) + 28'(rem_s5 >= 33'(gcd_pkg::DIV_C2));
		q_c  = (31'(m_s5) << 3) + 31'(m_s5) + 31'(q2_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s6  <= neg_s5 ? -34'(q_c) : 34'(q_c);
			fl_s6 <= fl_s5;
		end
	end

	// rotation CORDIC, one iteration per stage
	logic signed [33:0] x_sn [1:CORDIC_STEPS];
	logic signed [33:0] y_sn [1:CORDIC_STEPS];
	logic signed [33:0] z_sn [1:CORDIC_STEPS];
	logic               fl_sn [1:CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		localparam logic signed [33:0] ATN = 34'(gcd_pkg::atan_q30(k));
		logic signed [33:0] xi, yi, zi;
		logic               fi;
		if (k == 0) begin : g_first
			assign xi = X_INIT;
			assign yi = '0;
			assign zi = z_s6;
			assign fi = fl_s6;
		end else begin : g_next
			assign xi = x_sn[k];
			assign yi = y_sn[k];
			assign zi = z_sn[k];
			assign fi = fl_sn[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[33]) begin
					x_sn[k+1] <= xi - (yi >>> k);
					y_sn[k+1] <= yi + (xi >>> k);
					z_sn[k+1] <= zi - ATN;
				end else begin
					x_sn[k+1] <= xi + (yi >>> k);
					y_sn[k+1] <= yi - (xi >>> k);
					z_sn[k+1] <= zi + ATN;
				end
				fl_sn[k+1] <= fi;
			end
		end
	end

	// outputs, cosine negated past a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			sin_q <= 32'(y_sn[CORDIC_STEPS]);
			cos_q <= fl_sn[CORDIC_STEPS] ? 32'(-x_sn[CORDIC_STEPS]) : 32'(x_sn[CORDIC_STEPS]);
		end
	end

endmodule

/* hw/rtl/great_circle_distance.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// great_circle_distance - haversine distance between two points
// Fixed-point pipeline: CORDIC sine/cosine, haversine term, square roots,
// CORDIC atan2 and scaling by the sphere radius to whole metres.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries two points in microdegrees.
//    One transfer per cycle is taken while in_ready is high; no state links one item to the next.
//  - Output channel (out_valid/out_ready) returns one distance in metres per
//    input item, in order.
//  - Configuration channel (cfg_valid/cfg_ready) writes the sphere radius;
//    always ready. Write it only while no item is in flight.
//  - From input transfer to out_valid an item passes the two CORDIC chains in
//    series (sine/cosine, then atan2, one iteration per stage) and the 31-stage
//    square root chains.
//  - Throughput: one item per cycle while in_ready is high.
//  - When the receiver stalls, an output register plus one skid register
//    absorb the result; in_ready drops (registered) and the whole pipeline
//    holds until the skid register drains. Nothing is lost or repeated.
//  - Reset clears all valid bits, including out_valid, and loads the radius
//    with 6371000 m.
// ---------------------------------------------------------------------------
module great_circle_distance #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [22:0]        sphere_radius_m,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [27:0] first_lat_udeg,
	input  logic signed [28:0] first_lon_udeg,
	input  logic signed [27:0] second_lat_udeg,
	input  logic signed [28:0] second_lon_udeg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [24:0]        distance_m
);

	localparam int SC_LAT   = gcd_pkg::SC_PRE_STAGES + CORDIC_STEPS + 1;
	localparam int SQ_STEPS = 31;
	localparam int LAT      = 1 + SC_LAT + 7 + SQ_STEPS + CORDIC_STEPS + 3;

	logic [22:0]     radius_q;
	logic [LAT-1:0]  vld_q;
	logic            en;
	logic            out_vld_q;
	logic            skid_full_q;
	logic [24:0]     dist_q, skid_q;

	assign en        = !skid_full_q;
	assign in_ready  = en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_vld_q;
	assign distance_m = dist_q;

	// radius register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= gcd_pkg::RADIUS_RESET;
		else if (cfg_valid) radius_q <= sphere_radius_m;
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[LAT-2:0], in_valid};
	end

	// angle differences, in half-microdegrees
	logic signed [29:0] dlat_s0, dlon_s0, lat1_s0, lat2_s0;

	always_ff @(posedge clk) begin
		if (en) begin
			dlat_s0 <= {{2{second_lat_udeg[27]}}, second_lat_udeg}
				- {{2{first_lat_udeg[27]}}, first_lat_udeg};
			dlon_s0 <= {second_lon_udeg[28], second_lon_udeg}
				- {first_lon_udeg[28], first_lon_udeg};
			lat1_s0 <= {first_lat_udeg[27], first_lat_udeg, 1'b0};
			lat2_s0 <= {second_lat_udeg[27], second_lat_udeg, 1'b0};
		end
	end

	// sine and cosine units
	logic signed [31:0] sd, sl, c1, c2;

	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_dlat (
		.clk(clk), .en(en), .angle(dlat_s0), .sin_q(sd), .cos_q());
	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_dlon (
		.clk(clk), .en(en), .angle(dlon_s0), .sin_q(sl), .cos_q());
	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat1 (
		.clk(clk), .en(en), .angle(lat1_s0), .sin_q(), .cos_q(c1));
	gcd_sincos #(.CORDIC_STEPS(CORDIC_STEPS)) u_sc_lat2 (
		.clk(clk), .en(en), .angle(lat2_s0), .sin_q(), .cos_q(c2));

	// haversine term a = sd^2 + round(round(c1*c2)*sl)*sl
	logic signed [63:0] p12_s1, sq_s1, sq_s2, sq_s3, sq_s4, sq_s5, tp_s3, ts_s5;
	logic signed [31:0] sl_s1, sl_s2, sl_s3, sl_s4, c12_s2, t_s4;
	logic signed [65:0] sum_s6;
	logic [60:0]        a_s7, b_s7;
	logic signed [63:0] r12_c, rt_c;
	logic [60:0]        a_c;

	assign r12_c = p12_s1 + 64'sd536870912;
	assign rt_c  = tp_s3 + 64'sd536870912;

	always_comb begin
		if (sum_s6[65]) a_c = '0;
		else if (sum_s6 > $signed({2'b00, gcd_pkg::ONE60})) a_c = 61'(gcd_pkg::ONE60);
		else a_c = sum_s6[60:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p12_s1 <= 64'(c1) * 64'(c2);
			sq_s1  <= 64'(sd) * 64'(sd);
			sl_s1  <= sl;
			c12_s2 <= 32'(r12_c >>> 30);
			sq_s2  <= sq_s1;
			sl_s2  <= sl_s1;
			tp_s3  <= 64'(c12_s2) * 64'(sl_s2);
			sq_s3  <= sq_s2;
			sl_s3  <= sl_s2;
			t_s4   <= 32'(rt_c >>> 30);
			sq_s4  <= sq_s3;
			sl_s4  <= sl_s3;
			ts_s5  <= 64'(t_s4) * 64'(sl_s4);
			sq_s5  <= sq_s4;
			sum_s6 <= 66'(sq_s5) + 66'(ts_s5);
			a_s7   <= a_c;
			b_s7   <= 61'(gcd_pkg::ONE60) - a_c;
		end
	end

	// floor square roots of a and 1-a, one result bit per stage
	logic [60:0] sa_v_sn [1:SQ_STEPS];
	logic [61:0] sa_r_sn [1:SQ_STEPS];
	logic [60:0] sb_v_sn [1:SQ_STEPS];
	logic [61:0] sb_r_sn [1:SQ_STEPS];

	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * j);
		logic [60:0] va, vb;
		logic [61:0] ra, rb, ta, tb;
		if (j == 0) begin : g_first
			assign va = a_s7;
			assign vb = b_s7;
			assign ra = '0;
			assign rb = '0;
		end else begin : g_next
			assign va = sa_v_sn[j];
			assign vb = sb_v_sn[j];
			assign ra = sa_r_sn[j];
			assign rb = sb_r_sn[j];
		end
		assign ta = ra + BIT;
		assign tb = rb + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, va} >= ta) begin
					sa_v_sn[j+1] <= va - ta[60:0];
					sa_r_sn[j+1] <= (ra >> 1) + BIT;
				end else begin
					sa_v_sn[j+1] <= va;
					sa_r_sn[j+1] <= ra >> 1;
				end
				if ({1'b0, vb} >= tb) begin
					sb_v_sn[j+1] <= vb - tb[60:0];
					sb_r_sn[j+1] <= (rb >> 1) + BIT;
				end else begin
					sb_v_sn[j+1] <= vb;
					sb_r_sn[j+1] <= rb >> 1;
				end
			end
		end
	end

	// vectoring CORDIC: half the central angle = atan2(sqrt a, sqrt(1-a))
	logic signed [49:0] vx_sn [1:CORDIC_STEPS];
	logic signed [49:0] vy_sn [1:CORDIC_STEPS];
	logic signed [33:0] vz_sn [1:CORDIC_STEPS];

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec
		localparam logic signed [33:0] ATN = 34'(gcd_pkg::atan_q30(k));
		logic signed [49:0] xi, yi;
		logic signed [33:0] zi;
		if (k == 0) begin : g_first
			assign xi = $signed({3'b000, sb_r_sn[SQ_STEPS][30:0], 16'd0});
			assign yi = $signed({3'b000, sa_r_sn[SQ_STEPS][30:0], 16'd0});
			assign zi = '0;
		end else begin : g_next
			assign xi = vx_sn[k];
			assign yi = vy_sn[k];
			assign zi = vz_sn[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[49]) begin
					vx_sn[k+1] <= xi + (yi >>> k);
					vy_sn[k+1] <= yi - (xi >>> k);
					vz_sn[k+1] <= zi + ATN;
				end else begin
					vx_sn[k+1] <= xi - (yi >>> k);
					vy_sn[k+1] <= yi + (xi >>> k);
					vz_sn[k+1] <= zi - ATN;
				end
			end
		end
	end

	// central angle, scale by radius, round to metres
	logic [32:0] c_s8;
	logic [55:0] prod_s9;
	logic [55:0] rnd_c;
	logic [24:0] dist_s10;

	assign rnd_c = prod_s9 + (56'(1) << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			c_s8     <= vz_sn[CORDIC_STEPS][33] ? '0 : {vz_sn[CORDIC_STEPS][31:0], 1'b0};
			prod_s9  <= 56'(radius_q) * 56'(c_s8);
			dist_s10 <= rnd_c[54:30];
		end
	end

	// output register with one skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (en && vld_q[LAT-1]) begin
			if (!out_vld_q || out_ready) out_vld_q <= 1'b1;
			else skid_full_q <= 1'b1;
		end else if (skid_full_q && out_ready) begin
			skid_full_q <= 1'b0;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_q[LAT-1]) begin
			if (!out_vld_q || out_ready) dist_q <= dist_s10;
			else skid_q <= dist_s10;
		end else if (skid_full_q && out_ready) begin
			dist_q <= skid_q;
		end
	end

	// checks
	a_skid_has_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_full_q |-> out_vld_q)
		else $error("skid register full without a held result");

	a_skid_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_full_q) |-> $past(out_vld_q && !out_ready && vld_q[LAT-1]))
		else $error("skid register filled without a stalled transfer");

	a_out_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_ready && !skid_full_q && !vld_q[LAT-1] |=> !out_vld_q)
		else $error("output still valid after its transfer");

endmodule

/* dv/tb_great_circle_distance.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_great_circle_distance - self-checking bench for the haversine block
// Sends point pairs in random bursts and stalls the result channel on a
// changing pattern. Each transfer is predicted by a bit-exact fixed-point
// model of the haversine pipeline, and the results are checked in order.
// The sphere radius is changed between phases, its extremes among them.
// ---------------------------------------------------------------------------
module tb_great_circle_distance;

	localparam int STEPS      = 24;
	localparam int LATENCY    = 2 * STEPS + 49;
	localparam int SETTLE     = LATENCY + 30;
	localparam int N_RANDOM   = 1200;
	localparam longint unsigned Q60 = 64'h1000_0000_0000_0000;
	localparam longint TURN   = 720000000;
	localparam longint HTURN  = 360000000;
	localparam longint QTURN  = 180000000;
	localparam int LAT_MAX    = 90000000;
	localparam int LON_MAX    = 180000000;

	typedef struct {
		logic signed [27:0] lat_a;
		logic signed [28:0] lon_a;
		logic signed [27:0] lat_b;
		logic signed [28:0] lon_b;
	} point_pair_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [22:0]        sphere_radius_m;
	logic               in_valid;
	logic               in_ready;
	logic signed [27:0] first_lat_udeg;
	logic signed [28:0] first_lon_udeg;
	logic signed [27:0] second_lat_udeg;
	logic signed [28:0] second_lon_udeg;
	logic               out_valid;
	logic               out_ready;
	logic [24:0]        distance_m;

	great_circle_distance #(.CORDIC_STEPS(STEPS)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.sphere_radius_m (sphere_radius_m),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.first_lat_udeg  (first_lat_udeg),
		.first_lon_udeg  (first_lon_udeg),
		.second_lat_udeg (second_lat_udeg),
		.second_lon_udeg (second_lon_udeg),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distance_m      (distance_m)
	);

	point_pair_t        pending_pairs[$];
	logic [24:0]        distances_due[$];
	logic [22:0]        radius_now;
	int                 n_errors;

	// CORDIC constants, derived at start-up
	longint             arctan_q30[STEPS];
	longint             cordic_inv_gain;
	longint unsigned    pi_q32;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned rem, res, b;
		rem = v;
		res = 0;
		b   = 64'd1 << 62;
		while (b > rem) b = b >> 2;
		while (b != 0) begin
			if (rem >= res + b) begin
				rem = rem - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// atan(1/n) in Q60, alternating series
	function automatic longint unsigned arctan_recip(input longint unsigned n);
		longint unsigned pw, sum, k, t;
		pw  = Q60 / n;
		sum = 0;
		k   = 0;
		while (pw != 0) begin
			t = pw / (2 * k + 1);
			if (k[0]) sum = sum - t;
			else sum = sum + t;
			pw = pw / (n * n);
			k++;
		end
		return sum;
	endfunction

	// atan(2^-i) in Q60
	function automatic longint unsigned arctan_pow2(input int i);
		longint unsigned pw, sum, k, t;
		pw  = Q60 >> i;
		sum = 0;
		k   = 0;
		while (pw != 0) begin
			t = pw / (2 * k + 1);
			if (k[0]) sum = sum - t;
			else sum = sum + t;
			pw = (2 * i >= 64) ? 64'd0 : (pw >> (2 * i));
			k++;
		end
		return sum;
	endfunction

	function automatic void derive_cordic_constants();
		longint unsigned quarter_pi, g2, gain;
		quarter_pi = 4 * arctan_recip(5) - arctan_recip(239);
		pi_q32 = (4 * quarter_pi + (64'd1 << 27)) >> 28;
		arctan_q30[0] = longint'((quarter_pi + (64'd1 << 29)) >> 30);
		for (int i = 1; i < STEPS; i++)
			arctan_q30[i] = longint'((arctan_pow2(i) + (64'd1 << 29)) >> 30);
		g2 = Q60;
		for (int i = 0; i < STEPS; i++)
			if (2 * i < 64) g2 = g2 + (g2 >> (2 * i));
		gain = floor_sqrt(g2);
		cordic_inv_gain = longint'((Q60 + gain / 2) / gain);
	endfunction

	// sine and cosine in Q2.30 of an angle in half-microdegrees
	function automatic void sin_cos_q30(input longint ang, output longint s,
		output longint c);
		longint r, x, y, z, dx, dy;
		longint unsigned m, q;
		bit flip;
		flip = 1'b0;
		r = ang % TURN;
		if (r < 0) r = r + TURN;
		if (r >= HTURN) r = r - TURN;
		// fold into a quarter turn, remembering the cosine sign
		if (r > QTURN) begin
			r = HTURN - r;
			flip = 1'b1;
		end else if (r < -QTURN) begin
			r = -HTURN - r;
			flip = 1'b1;
		end
		m = longint'(r < 0 ? -r : r);
		q = (m * pi_q32 + 64'd720000000) / 64'd1440000000;
		z = (r < 0) ? -longint'(q) : longint'(q);
		x = cordic_inv_gain;
		y = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - arctan_q30[i];
			end else begin
				x = x + dx; y = y - dy; z = z + arctan_q30[i];
			end
		end
		s = y;
		c = flip ? -x : x;
	endfunction

	function automatic logic [24:0] haversine_metres(input point_pair_t p,
		input logic [22:0] radius);
		longint lat1, lon1, lat2, lon2;
		longint sd, cd, sl, cl, s1, c1, s2, c2, c12, t, a, x, y, z, dx, dy, ca;
		longint unsigned ra, rb, metres;
		lat1 = longint'(p.lat_a);
		lon1 = longint'(p.lon_a);
		lat2 = longint'(p.lat_b);
		lon2 = longint'(p.lon_b);
		sin_cos_q30(lat2 - lat1, sd, cd);
		sin_cos_q30(lon2 - lon1, sl, cl);
		sin_cos_q30(2 * lat1, s1, c1);
		sin_cos_q30(2 * lat2, s2, c2);
		// haversine term in Q60, clamped to [0,1]
		c12 = (c1 * c2 + (64'sd1 <<< 29)) >>> 30;
		t   = (c12 * sl + (64'sd1 <<< 29)) >>> 30;
		a   = sd * sd + t * sl;
		if (a < 0) a = 0;
		if (a > longint'(Q60)) a = longint'(Q60);
		ra = floor_sqrt(longint'(a));
		rb = floor_sqrt(Q60 - longint'(a));
		// atan2 by vectoring CORDIC
		x = longint'(rb << 16);
		y = longint'(ra << 16);
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx; y = y - dy; z = z + arctan_q30[i];
			end else begin
				x = x - dx; y = y + dy; z = z - arctan_q30[i];
			end
		end
		ca = 2 * z;
		if (ca < 0) ca = 0;
		metres = (longint'(radius) * ca + (64'd1 << 29)) >> 30;
		return metres[24:0];
	endfunction

	// sender: bursts of random length separated by random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		point_pair_t nxt;
		point_pair_t cur;
		if (!arst_n) begin
			in_valid        <= 1'b0;
			first_lat_udeg  <= '0;
			first_lon_udeg  <= '0;
			second_lat_udeg <= '0;
			second_lon_udeg <= '0;
			burst_left      <= 4;
			gap_left        <= 0;
		end else begin
			if (in_valid && in_ready) begin
				cur.lat_a = first_lat_udeg;
				cur.lon_a = first_lon_udeg;
				cur.lat_b = second_lat_udeg;
				cur.lon_b = second_lon_udeg;
				distances_due.push_back(haversine_metres(cur, radius_now));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_pairs.size() > 0) begin
					nxt = pending_pairs.pop_front();
					first_lat_udeg  <= nxt.lat_a;
					first_lon_udeg  <= nxt.lon_a;
					second_lat_udeg <= nxt.lat_b;
					second_lon_udeg <= nxt.lon_b;
					in_valid        <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(40, 1);
						gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks results in order under a randomly redrawn stall pattern
	int stall_mode;
	int stall_count;
	always @(posedge clk or negedge arst_n) begin
		logic [24:0] want;
		if (!arst_n) begin
			out_ready   <= 1'b0;
			stall_mode  <= 0;
			stall_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (distances_due.size() == 0) begin
					$error("distance_m: unexpected transfer, actual %0d", distance_m);
					n_errors++;
				end else begin
					want = distances_due.pop_front();
					if (distance_m !== want) begin
						$error("distance_m: expected %0d actual %0d", want, distance_m);
						n_errors++;
					end
				end
			end
			stall_count <= stall_count + 1;
			if (stall_count % 64 == 63) stall_mode <= $urandom_range(3);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(1));
				2: out_ready <= ($urandom_range(7) == 0);
				default: out_ready <= (stall_count % 5 != 0);
			endcase
		end
	end

	function automatic point_pair_t make_pair(input int la, input int oa, input int lb,
		input int ob);
		point_pair_t p;
		p.lat_a = la[27:0];
		p.lon_a = oa[28:0];
		p.lat_b = lb[27:0];
		p.lon_b = ob[28:0];
		return p;
	endfunction

	function automatic int rand_lat();
		return int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
	endfunction

	function automatic int rand_lon();
		return int'($urandom_range(2 * LON_MAX)) - LON_MAX;
	endfunction

	task automatic queue_random(input int n);
		int la, oa, kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(9);
			la = rand_lat();
			oa = rand_lon();
			if (kind < 7) begin
				pending_pairs.push_back(make_pair(la, oa, rand_lat(), rand_lon()));
			end else if (kind == 7) begin
				// nearby or near-antipodal partner
				if ($urandom_range(1))
					pending_pairs.push_back(make_pair(la, oa,
						la + int'($urandom_range(2000)) - 1000,
						oa + int'($urandom_range(2000)) - 1000));
				else
					pending_pairs.push_back(make_pair(la, oa, -la,
						oa + ((oa > 0) ? -LON_MAX : LON_MAX) + int'($urandom_range(200)) - 100));
			end else begin
				// raw bit patterns, out-of-range angles included
				pending_pairs.push_back(make_pair($urandom, $urandom, $urandom, $urandom));
			end
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_pairs.size() != 0 || in_valid || distances_due.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_radius(input logic [22:0] r);
		@(posedge clk);
		cfg_valid       <= 1'b1;
		sphere_radius_m <= r;
		do @(posedge clk);
		while (!cfg_ready);
		radius_now = r;
		cfg_valid <= 1'b0;
	endtask

	// stimulus and phase control
	initial begin
		n_errors        = 0;
		radius_now      = 23'd6371000;
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		sphere_radius_m = '0;
		derive_cordic_constants();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: poles, equator, date line, antipodes, field extremes
		pending_pairs.push_back(make_pair(0, 0, 0, 0));
		pending_pairs.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
		pending_pairs.push_back(make_pair(0, 0, 0, LON_MAX));
		pending_pairs.push_back(make_pair(0, -LON_MAX, 0, LON_MAX));
		pending_pairs.push_back(make_pair(0, 0, 0, -LON_MAX));
		pending_pairs.push_back(make_pair(45000000, 90000000, -45000000, -90000000));
		pending_pairs.push_back(make_pair(LAT_MAX, 0, LAT_MAX, LON_MAX));
		pending_pairs.push_back(make_pair(0, 179999999, 0, -179999999));
		pending_pairs.push_back(make_pair(51500000, -120000, 48850000, 2350000));
		pending_pairs.push_back(make_pair(0, 0, 0, 1));
		pending_pairs.push_back(make_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX));
		pending_pairs.push_back(make_pair(32'h07FF_FFFF, 32'h0FFF_FFFF,
			32'hF800_0000, 32'hF000_0000));
		pending_pairs.push_back(make_pair(32'hF800_0000, 32'hF000_0000,
			32'h07FF_FFFF, 32'h0FFF_FFFF));
		pending_pairs.push_back(make_pair(120000000, 0, -120000000, 30000000));
		pending_pairs.push_back(make_pair(-1, -1, 1, 1));
		wait_idle();

		// radius sweep, extremes and a reload of the earth radius
		write_radius(23'd0);
		queue_random(60);
		wait_idle();
		write_radius(23'd8388607);
		pending_pairs.push_back(make_pair(0, 0, 0, LON_MAX));
		pending_pairs.push_back(make_pair(LAT_MAX, 0, -LAT_MAX, 0));
		queue_random(300);
		wait_idle();
		write_radius(23'd1);
		queue_random(100);
		wait_idle();
		write_radius(23'($urandom_range(8388607, 1)));
		queue_random(240);
		wait_idle();
		write_radius(23'd6371000);
		queue_random(N_RANDOM - 700);
		wait_idle();

		if (n_errors == 0)
			$display("great_circle_distance test passed");
		else
			$display("great_circle_distance test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("great_circle_distance test failed");
		$finish;
	end

endmodule
